/* design/i2cee_pkg.sv */
package i2cee_pkg;

    // Request kinds carried in the kind field of an input item.
    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_WRITE = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_DEVICE_ADDRESS = 2'd0;
    localparam logic [1:0] CFG_ACK_TIMEOUT    = 2'd1;
    localparam logic [1:0] CFG_READ_GAP       = 2'd2;
    localparam logic [1:0] CFG_WRITE_GAP      = 2'd3;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    // Reset values of the configuration registers.
    localparam logic [6:0]  RST_DEVICE_ADDRESS = 7'd80;
    localparam logic [7:0]  RST_ACK_TIMEOUT    = 8'd255;
    localparam logic [15:0] RST_READ_GAP       = 16'd100;
    localparam logic [15:0] RST_WRITE_GAP      = 16'd5000;

    // One input item: a bus tick with an optional request.
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] word_address;
        logic [7:0] write_data;
        logic       sda_in;
    } in_item_t;

    // One result item: pin levels and status for the tick.
    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_result;
        logic       ack_missing;
    } out_item_t;

    // Current configuration as seen by the sequencer.
    typedef struct packed {
        logic [6:0]  device_address;
        logic [7:0]  ack_timeout_ticks;
        logic [15:0] read_gap_ticks;
        logic [15:0] write_gap_ticks;
    } cfg_t;

endpackage

/* design/i2c_eeprom_byte_master_unit.sv */
// The result for an input item is registered and presented in the cycle after acceptance.
// Throughput: one item per cycle when not stalled; each item is one bus tick, so a byte
// write or random read takes as many items as its bus ticks plus the configured gap.
// The output register sets the pace: a new item is taken whenever it is empty or drained.
// Reset (aresetn, synchronous, active low) returns the sequencer to idle, clears the
// read byte and flags, and loads the configuration registers with their defaults.
module i2c_eeprom_byte_master_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  i2cee_pkg::in_item_t                 s_item,
    output logic                                m_valid,
    input  logic                                m_ready,
    output i2cee_pkg::out_item_t                m_item,
    input  logic                                cfg_we,
    input  logic [i2cee_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [i2cee_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import i2cee_pkg::*;

    cfg_t      cfg;
    out_item_t result;
    out_item_t m_item_reg;
    logic      m_valid_reg;
    logic      accept;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    i2cee_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    i2cee_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (accept),
        .item    (s_item),
        .cfg     (cfg),
        .result  (result)
    );

    // Output valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Output payload register.
    always_ff @(posedge aclk) begin
        if (accept) begin
            m_item_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

/* design/i2cee_cfg.sv */
module i2cee_cfg (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [i2cee_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [i2cee_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    output i2cee_pkg::cfg_t                     cfg
);
    import i2cee_pkg::*;

    logic [6:0]  device_address_reg;
    logic [7:0]  ack_timeout_reg;
    logic [15:0] read_gap_reg;
    logic [15:0] write_gap_reg;

    // Register file, loaded one register per write.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            device_address_reg <= RST_DEVICE_ADDRESS;
            ack_timeout_reg    <= RST_ACK_TIMEOUT;
            read_gap_reg       <= RST_READ_GAP;
            write_gap_reg      <= RST_WRITE_GAP;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_DEVICE_ADDRESS: device_address_reg <= cfg_wdata[6:0];
                CFG_ACK_TIMEOUT:    ack_timeout_reg    <= cfg_wdata[7:0];
                CFG_READ_GAP:       read_gap_reg       <= cfg_wdata;
                CFG_WRITE_GAP:      write_gap_reg      <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign cfg.device_address    = device_address_reg;
    assign cfg.ack_timeout_ticks = ack_timeout_reg;
    assign cfg.read_gap_ticks    = read_gap_reg;
    assign cfg.write_gap_ticks   = write_gap_reg;

endmodule

/* design/i2cee_seq.sv */
module i2cee_seq (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  step,
    input  i2cee_pkg::in_item_t   item,
    input  i2cee_pkg::cfg_t       cfg,
    output i2cee_pkg::out_item_t  result
);
    import i2cee_pkg::*;

    // Bus phases of the transaction sequencer.
    localparam logic [4:0] PH_IDLE    = 5'd0;
    localparam logic [4:0] PH_ST_HI   = 5'd1;
    localparam logic [4:0] PH_ST_FALL = 5'd2;
    localparam logic [4:0] PH_ST_LOW  = 5'd3;
    localparam logic [4:0] PH_BIT_LOW = 5'd4;
    localparam logic [4:0] PH_BIT_HI  = 5'd5;
    localparam logic [4:0] PH_REL     = 5'd6;
    localparam logic [4:0] PH_ACK_W   = 5'd7;
    localparam logic [4:0] PH_ACK_LOW = 5'd8;
    localparam logic [4:0] PH_RD_HI   = 5'd9;
    localparam logic [4:0] PH_RD_LOW  = 5'd10;
    localparam logic [4:0] PH_NK_HI   = 5'd11;
    localparam logic [4:0] PH_NK_LOW  = 5'd12;
    localparam logic [4:0] PH_SP_LOW  = 5'd13;
    localparam logic [4:0] PH_SP_RISE = 5'd14;
    localparam logic [4:0] PH_SP_HI   = 5'd15;
    localparam logic [4:0] PH_GAP     = 5'd16;

    localparam logic [3:0] BITS_PER_BYTE = 4'd8;
    localparam logic [2:0] IDX_DEV_WR    = 3'd0;
    localparam logic [2:0] IDX_WORD      = 3'd1;
    localparam logic [2:0] IDX_THIRD     = 3'd2;
    localparam logic [2:0] IDX_DONE      = 3'd3;

    logic [4:0]  phase_reg, phase_next, phase_cur;
    logic [3:0]  bit_counter_reg, bit_counter_next, bit_counter_inc;
    logic [2:0]  byte_index_reg, byte_index_next;
    logic [7:0]  shift_byte_reg, shift_byte_next;
    logic [7:0]  ack_wait_reg, ack_wait_next, ack_wait_inc;
    logic [15:0] gap_count_reg, gap_count_next;
    logic [7:0]  held_address_reg, held_address_next;
    logic [7:0]  held_data_reg, held_data_next;
    logic        is_write_reg, is_write_next;
    logic        ack_flag_reg, ack_flag_next;
    logic [7:0]  last_read_reg, last_read_next;
    logic        request;
    logic        scl, sda, busy, done;

    assign request = (phase_reg == PH_IDLE) &&
                     ((item.kind == KIND_READ) || (item.kind == KIND_WRITE));
    assign phase_cur       = request ? PH_ST_HI : phase_reg;
    assign bit_counter_inc = bit_counter_reg + 4'd1;
    assign ack_wait_inc    = ack_wait_reg + 8'd1;

    // Next state and pin levels for the current tick.
    always_comb begin
        phase_next        = phase_cur;
        bit_counter_next  = bit_counter_reg;
        byte_index_next   = request ? IDX_DEV_WR : byte_index_reg;
        shift_byte_next   = shift_byte_reg;
        ack_wait_next     = ack_wait_reg;
        gap_count_next    = gap_count_reg;
        held_address_next = request ? item.word_address : held_address_reg;
        held_data_next    = request ? item.write_data : held_data_reg;
        is_write_next     = request ? (item.kind == KIND_WRITE) : is_write_reg;
        ack_flag_next     = request ? 1'b0 : ack_flag_reg;
        last_read_next    = last_read_reg;
        scl  = 1'b1;
        sda  = 1'b1;
        busy = 1'b1;
        done = 1'b0;

        unique case (phase_cur)
            PH_ST_HI: begin
                phase_next = PH_ST_FALL;
            end
            PH_ST_FALL: begin
                sda        = 1'b0;
                phase_next = PH_ST_LOW;
            end
            PH_ST_LOW: begin
                scl              = 1'b0;
                sda              = 1'b0;
                // The read direction bit is set on the address after the repeated start.
                shift_byte_next  = {cfg.device_address, (byte_index_reg == IDX_THIRD)};
                bit_counter_next = 4'd0;
                phase_next       = PH_BIT_LOW;
            end
            PH_BIT_LOW: begin
                scl        = 1'b0;
                sda        = shift_byte_reg[7];
                phase_next = PH_BIT_HI;
            end
            PH_BIT_HI: begin
                sda              = shift_byte_reg[7];
                shift_byte_next  = {shift_byte_reg[6:0], 1'b0};
                bit_counter_next = bit_counter_inc;
                phase_next       = (bit_counter_inc >= BITS_PER_BYTE) ? PH_REL : PH_BIT_LOW;
            end
            PH_REL: begin
                scl           = 1'b0;
                ack_wait_next = 8'd0;
                phase_next    = PH_ACK_W;
            end
            PH_ACK_W: begin
                // Hold SCL high until the slave pulls SDA low or time runs out.
                if (!item.sda_in) begin
                    phase_next = PH_ACK_LOW;
                end else begin
                    ack_wait_next = ack_wait_inc;
                    if (ack_wait_inc >= cfg.ack_timeout_ticks) begin
                        ack_flag_next = 1'b1;
                        phase_next    = PH_ACK_LOW;
                    end
                end
            end
            PH_ACK_LOW: begin
                scl = 1'b0;
                priority if (byte_index_reg == IDX_DEV_WR) begin
                    byte_index_next  = IDX_WORD;
                    shift_byte_next  = held_address_reg;
                    bit_counter_next = 4'd0;
                    phase_next       = PH_BIT_LOW;
                end else if (byte_index_reg == IDX_WORD) begin
                    byte_index_next = IDX_THIRD;
                    if (is_write_reg) begin
                        shift_byte_next  = held_data_reg;
                        bit_counter_next = 4'd0;
                        phase_next       = PH_BIT_LOW;
                    end else begin
                        phase_next = PH_ST_HI;
                    end
                end else begin
                    byte_index_next = IDX_DONE;
                    if (is_write_reg) begin
                        phase_next = PH_SP_LOW;
                    end else begin
                        bit_counter_next = 4'd0;
                        shift_byte_next  = 8'd0;
                        phase_next       = PH_RD_HI;
                    end
                end
            end
            PH_RD_HI: begin
                shift_byte_next = {shift_byte_reg[6:0], item.sda_in};
                phase_next      = PH_RD_LOW;
            end
            PH_RD_LOW: begin
                scl              = 1'b0;
                bit_counter_next = bit_counter_inc;
                if (bit_counter_inc >= BITS_PER_BYTE) begin
                    last_read_next = shift_byte_reg;
                    phase_next     = PH_NK_HI;
                end else begin
                    phase_next = PH_RD_HI;
                end
            end
            PH_NK_HI: begin
                phase_next = PH_NK_LOW;
            end
            PH_NK_LOW: begin
                scl        = 1'b0;
                phase_next = PH_SP_LOW;
            end
            PH_SP_LOW: begin
                scl        = 1'b0;
                sda        = 1'b0;
                phase_next = PH_SP_RISE;
            end
            PH_SP_RISE: begin
                sda        = 1'b0;
                phase_next = PH_SP_HI;
            end
            PH_SP_HI: begin
                gap_count_next = is_write_reg ? cfg.write_gap_ticks : cfg.read_gap_ticks;
                phase_next     = PH_GAP;
            end
            PH_GAP: begin
                if (gap_count_reg != 16'd0) begin
                    gap_count_next = gap_count_reg - 16'd1;
                end else begin
                    busy       = 1'b0;
                    done       = 1'b1;
                    phase_next = PH_IDLE;
                end
            end
            default: begin
                busy       = 1'b0;
                phase_next = PH_IDLE;
            end
        endcase
    end

    // Sequencer state advances once per accepted item.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_IDLE;
            bit_counter_reg  <= 4'd0;
            byte_index_reg   <= 3'd0;
            shift_byte_reg   <= 8'd0;
            ack_wait_reg     <= 8'd0;
            gap_count_reg    <= 16'd0;
            held_address_reg <= 8'd0;
            held_data_reg    <= 8'd0;
            is_write_reg     <= 1'b0;
            ack_flag_reg     <= 1'b0;
            last_read_reg    <= 8'd0;
        end else if (step) begin
            phase_reg        <= phase_next;
            bit_counter_reg  <= bit_counter_next;
            byte_index_reg   <= byte_index_next;
            shift_byte_reg   <= shift_byte_next;
            ack_wait_reg     <= ack_wait_next;
            gap_count_reg    <= gap_count_next;
            held_address_reg <= held_address_next;
            held_data_reg    <= held_data_next;
            is_write_reg     <= is_write_next;
            ack_flag_reg     <= ack_flag_next;
            last_read_reg    <= last_read_next;
        end
    end

    assign result.scl_out     = scl;
    assign result.sda_out     = sda;
    assign result.busy_res    = busy;
    assign result.done_res    = done;
    assign result.read_result = last_read_next;
    assign result.ack_missing = ack_flag_next;

endmodule

/* dv/tb_i2c_eeprom_byte_master_unit.sv */
module tb_i2c_eeprom_byte_master_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import i2cee_pkg::*;

    // Kind value with no meaning of its own; the block treats it as a plain tick.
    localparam logic [1:0] KIND_SPARE = 2'd3;

    // Bus sequencer phases of the predictor.
    typedef enum logic [4:0] {
        BUS_IDLE, START_HI, START_FALL, START_LOW, BIT_LOW, BIT_HI,
        ACK_RELEASE, ACK_WAIT, ACK_LOW, RD_HI, RD_LOW, NACK_HI, NACK_LOW,
        STOP_LOW, STOP_RISE, STOP_HI, GAP_WAIT
    } bus_phase_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    in_item_t   s_item = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    out_item_t  m_item;
    logic       cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;

    // Stimulus and expectation stores.
    in_item_t   pending_ticks[$];
    out_item_t  expected_pins[$];
    int         items_queued = 0;
    int         mismatch_count = 0;
    int         send_idle_pct = 11;
    int         recv_idle_pct = 82;
    bit         hold_sender = 1'b0;
    bit         item_taken = 1'b0;

    // Configuration copy of the predictor.
    logic [6:0]  dev_addr_reg = RST_DEVICE_ADDRESS;
    logic [7:0]  ack_limit_reg = RST_ACK_TIMEOUT;
    logic [15:0] read_gap_reg = RST_READ_GAP;
    logic [15:0] write_gap_reg = RST_WRITE_GAP;

    // Sequencer state of the predictor.
    bus_phase_t  bus_phase = BUS_IDLE;
    logic [3:0]  bit_cnt = '0;
    logic [2:0]  byte_idx = '0;
    logic [7:0]  shift_reg = '0;
    logic [7:0]  ack_wait = '0;
    logic [15:0] gap_left = '0;
    logic [7:0]  req_address = '0;
    logic [7:0]  req_data = '0;
    logic        req_is_write = 1'b0;
    logic        ack_timed_out = 1'b0;
    logic [7:0]  last_read_byte = '0;

    i2c_eeprom_byte_master_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #6 aclk = ~aclk;

    // Start shifting one byte out on the bus.
    function automatic void load_byte(logic [7:0] b);
        shift_reg = b;
        bit_cnt = '0;
        bus_phase = BIT_LOW;
    endfunction

    // Advance the bus sequencer by one tick and return the pins and status it shows.
    function automatic out_item_t predict_bus_tick(in_item_t it);
        out_item_t o;
        o = '0;
        o.scl_out = 1'b1;
        o.sda_out = 1'b1;
        o.busy_res = 1'b1;
        if (bus_phase == BUS_IDLE && (it.kind == KIND_READ || it.kind == KIND_WRITE)) begin
            req_address = it.word_address;
            req_data = it.write_data;
            req_is_write = (it.kind == KIND_WRITE);
            ack_timed_out = 1'b0;
            byte_idx = '0;
            bus_phase = START_HI;
        end
        case (bus_phase)
            START_HI: bus_phase = START_FALL;
            START_FALL: begin
                o.sda_out = 1'b0;
                bus_phase = START_LOW;
            end
            START_LOW: begin
                o.scl_out = 1'b0;
                o.sda_out = 1'b0;
                // The third address byte is the repeated start of a read.
                load_byte({dev_addr_reg, byte_idx == 3'd2});
            end
            BIT_LOW: begin
                o.scl_out = 1'b0;
                o.sda_out = shift_reg[7];
                bus_phase = BIT_HI;
            end
            BIT_HI: begin
                o.sda_out = shift_reg[7];
                shift_reg = {shift_reg[6:0], 1'b0};
                bit_cnt = bit_cnt + 4'd1;
                if (bit_cnt >= 4'd8) bus_phase = ACK_RELEASE;
                else bus_phase = BIT_LOW;
            end
            ACK_RELEASE: begin
                o.scl_out = 1'b0;
                ack_wait = '0;
                bus_phase = ACK_WAIT;
            end
            ACK_WAIT: begin
                if (!it.sda_in) begin
                    bus_phase = ACK_LOW;
                end else begin
                    ack_wait = ack_wait + 8'd1;
                    if (ack_wait >= ack_limit_reg) begin
                        ack_timed_out = 1'b1;
                        bus_phase = ACK_LOW;
                    end
                end
            end
            ACK_LOW: begin
                o.scl_out = 1'b0;
                if (byte_idx == 3'd0) begin
                    byte_idx = 3'd1;
                    load_byte(req_address);
                end else if (byte_idx == 3'd1) begin
                    byte_idx = 3'd2;
                    if (req_is_write) load_byte(req_data);
                    else bus_phase = START_HI;
                end else begin
                    byte_idx = 3'd3;
                    if (req_is_write) begin
                        bus_phase = STOP_LOW;
                    end else begin
                        bit_cnt = '0;
                        shift_reg = '0;
                        bus_phase = RD_HI;
                    end
                end
            end
            RD_HI: begin
                shift_reg = {shift_reg[6:0], it.sda_in};
                bus_phase = RD_LOW;
            end
            RD_LOW: begin
                o.scl_out = 1'b0;
                bit_cnt = bit_cnt + 4'd1;
                if (bit_cnt >= 4'd8) begin
                    last_read_byte = shift_reg;
                    bus_phase = NACK_HI;
                end else begin
                    bus_phase = RD_HI;
                end
            end
            NACK_HI: bus_phase = NACK_LOW;
            NACK_LOW: begin
                o.scl_out = 1'b0;
                bus_phase = STOP_LOW;
            end
            STOP_LOW: begin
                o.scl_out = 1'b0;
                o.sda_out = 1'b0;
                bus_phase = STOP_RISE;
            end
            STOP_RISE: begin
                o.sda_out = 1'b0;
                bus_phase = STOP_HI;
            end
            STOP_HI: begin
                gap_left = req_is_write ? write_gap_reg : read_gap_reg;
                bus_phase = GAP_WAIT;
            end
            GAP_WAIT: begin
                if (gap_left != 16'd0) begin
                    gap_left = gap_left - 16'd1;
                end else begin
                    o.busy_res = 1'b0;
                    o.done_res = 1'b1;
                    bus_phase = BUS_IDLE;
                end
            end
            default: begin
                o.busy_res = 1'b0;
                bus_phase = BUS_IDLE;
            end
        endcase
        o.read_result = last_read_byte;
        o.ack_missing = ack_timed_out;
        return o;
    endfunction

    task automatic report_mismatch(string msg);
        mismatch_count++;
        $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
        if (got !== want) report_mismatch($sformatf("%s got %0h, want %0h", name, got, want));
    endtask

    // Sender: offer the next queued item once the previous one has been taken.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || item_taken) begin
            item_taken = 1'b0;
            if (pending_ticks.size() != 0 && !hold_sender &&
                $urandom_range(99) >= send_idle_pct) begin
                s_item <= pending_ticks.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver: stall at random.
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Monitor: check each result against the oldest expectation, then predict new items.
    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_pins.size() == 0) begin
                    report_mismatch("result item with no item waiting");
                end else begin
                    want = expected_pins.pop_front();
                    check_field("scl_out", m_item.scl_out, want.scl_out);
                    check_field("sda_out", m_item.sda_out, want.sda_out);
                    check_field("busy_res", m_item.busy_res, want.busy_res);
                    check_field("done_res", m_item.done_res, want.done_res);
                    check_field("read_result", m_item.read_result, want.read_result);
                    check_field("ack_missing", m_item.ack_missing, want.ack_missing);
                end
            end
            if (s_valid && s_ready) begin
                item_taken = 1'b1;
                expected_pins.push_back(predict_bus_tick(s_item));
            end
        end
    end

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_DEVICE_ADDRESS: dev_addr_reg = val[6:0];
            CFG_ACK_TIMEOUT:    ack_limit_reg = val[7:0];
            CFG_READ_GAP:       read_gap_reg = val;
            CFG_WRITE_GAP:      write_gap_reg = val;
            default: ;
        endcase
    endtask

    task automatic set_config(logic [6:0] dev, logic [7:0] limit, logic [15:0] rgap,
                              logic [15:0] wgap);
        write_reg(CFG_DEVICE_ADDRESS, {9'd0, dev});
        write_reg(CFG_ACK_TIMEOUT, {8'd0, limit});
        write_reg(CFG_READ_GAP, rgap);
        write_reg(CFG_WRITE_GAP, wgap);
    endtask

    // A request item followed by bus ticks; SDA reads low with the given chance.
    task automatic push_transaction(logic [1:0] req_kind, logic [7:0] addr, logic [7:0] data,
                                    int low_pct, int len, bit noisy);
        in_item_t it;
        it.kind = req_kind;
        it.word_address = addr;
        it.write_data = data;
        it.sda_in = ($urandom_range(99) < low_pct);
        pending_ticks.push_back(it);
        repeat (len) begin
            it.kind = KIND_TICK;
            if (noisy && $urandom_range(99) < 8) it.kind = 2'($urandom_range(3));
            it.word_address = 8'($urandom);
            it.write_data = 8'($urandom);
            it.sda_in = ($urandom_range(99) < low_pct);
            pending_ticks.push_back(it);
        end
        items_queued += len + 1;
    endtask

    // A random transaction sized to finish under the current settings, now and then cut short.
    task automatic push_random_transaction();
        logic [1:0] req_kind;
        int low_pct;
        int budget;
        int len;
        req_kind = $urandom_range(1) ? KIND_WRITE : KIND_READ;
        case ($urandom_range(9))
            0: low_pct = 0;
            1: low_pct = 100;
            default: low_pct = $urandom_range(90, 20);
        endcase
        budget = (low_pct == 0) ? int'(ack_limit_reg) + 1 : 12;
        len = 88 + 3 * budget + $urandom_range(20) +
              ((req_kind == KIND_WRITE) ? int'(write_gap_reg) : int'(read_gap_reg));
        if ($urandom_range(7) == 0) len = $urandom_range(80, 10);
        push_transaction(req_kind, 8'($urandom), 8'($urandom), low_pct, len, 1'b1);
    endtask

    task automatic wait_drained();
        while (pending_ticks.size() != 0 || s_valid || expected_pins.size() != 0)
            @(posedge aclk);
    endtask

    // Feed plain ticks until the sequencer is back in idle, so settings can change.
    task automatic settle_idle();
        int n;
        in_item_t it;
        wait_drained();
        while (bus_phase != BUS_IDLE) begin
            n = (bus_phase == GAP_WAIT) ? int'(gap_left) + 2 : 64;
            repeat (n) begin
                it = '0;
                it.kind = KIND_TICK;
                it.sda_in = $urandom_range(1);
                pending_ticks.push_back(it);
            end
            wait_drained();
        end
    endtask

    task automatic run_random(int count);
        int start;
        start = items_queued;
        while (items_queued - start < count) push_random_transaction();
    endtask

    initial begin
        in_item_t it;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: idle ticks, the spare kind, a read at reset settings with a
        // request arriving while busy, which must be ignored.
        it = '0;
        it.kind = KIND_TICK;
        pending_ticks.push_back(it);
        it.kind = KIND_SPARE;
        it.word_address = 8'hff;
        it.write_data = 8'hff;
        it.sda_in = 1'b1;
        pending_ticks.push_back(it);
        push_transaction(KIND_READ, 8'h00, 8'h3c, 50, 10, 1'b0);
        push_transaction(KIND_WRITE, 8'h5a, 8'hc3, 100, 200, 1'b0);
        settle_idle();

        // Zero timeout and zero gaps: a missing acknowledge gives up at once, stop runs
        // straight into the done tick.
        set_config(7'd0, 8'd0, 16'd0, 16'd0);
        push_transaction(KIND_WRITE, 8'hff, 8'hff, 0, 80, 1'b0);
        push_transaction(KIND_READ, 8'hff, 8'h00, 0, 100, 1'b0);
        push_transaction(KIND_WRITE, 8'h00, 8'h00, 100, 80, 1'b0);
        push_transaction(KIND_READ, 8'ha5, 8'h5a, 50, 110, 1'b0);
        settle_idle();

        // Random, receiver mostly stalled; the sender holds off once until drained.
        set_config(7'($urandom), 8'd1, 16'($urandom_range(20)), 16'($urandom_range(20)));
        run_random(200);
        while (pending_ticks.size() > 100) @(posedge aclk);
        hold_sender = 1'b1;
        while (s_valid || expected_pins.size() != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
        hold_sender = 1'b0;
        settle_idle();

        // Random, sender mostly idle.
        send_idle_pct = 82;
        recv_idle_pct = 11;
        set_config(7'd127, 8'($urandom_range(12, 2)), 16'd0, 16'($urandom_range(30, 1)));
        run_random(200);
        settle_idle();

        // Full rate: a write whose acknowledges all run to the longest timeout.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_config(7'($urandom), 8'd255, 16'($urandom_range(40)), 16'($urandom_range(40)));
        push_transaction(KIND_WRITE, 8'($urandom), 8'($urandom), 0, 900, 1'b0);
        settle_idle();

        repeat (8) @(posedge aclk);
        if (expected_pins.size() != 0) report_mismatch("expected results left over");
        if (mismatch_count == 0) begin
            $display("tb_i2c_eeprom_byte_master_unit: clean");
        end else begin
            $display("tb_i2c_eeprom_byte_master_unit: errors");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #2_000_000;
        $display("tb_i2c_eeprom_byte_master_unit: errors");
        $finish;
    end

endmodule
